/* hw/rtl/cbc_pkg.sv */
// shared types and constants of the cartridge bank controller
package cbc_pkg;

    // field and address widths
    localparam int RomOffsetBits  = 14;
    localparam int RamOffsetBits  = 13;
    localparam int RomBankBits    = 7;
    localparam int RomAddrBits    = 21;
    localparam int RamIndexBits   = 15;
    localparam int RamBankSelBits = 2;
    localparam int CfgDataBits    = 3;
    localparam int CfgIndexBits   = 2;

    // bus access kinds
    typedef enum logic [2:0] {
        ACT_CONTROL    = 3'd0,
        ACT_ROM_FIXED  = 3'd1,
        ACT_ROM_BANKED = 3'd2,
        ACT_RAM_READ   = 3'd3,
        ACT_RAM_WRITE  = 3'd4
    } action_t;

    // control write regions, by bus address bits 14:13
    typedef enum logic [1:0] {
        REGION_ENABLE   = 2'd0,
        REGION_ROM_BANK = 2'd1,
        REGION_RAM_BANK = 2'd2,
        REGION_LATCH    = 2'd3
    } region_t;

    // work handed from front to back
    typedef enum logic [1:0] {
        KIND_PLAIN     = 2'd0,
        KIND_RAM_READ  = 2'd1,
        KIND_RAM_WRITE = 2'd2
    } kind_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROM_SIZE = 2'd0,
        CFG_RAM_SIZE = 2'd1,
        CFG_RTC      = 2'd2
    } cfg_index_t;

    // ram size codes
    localparam logic [1:0] RamNone      = 2'd0;
    localparam logic [1:0] RamOneBank   = 2'd1;
    localparam logic [1:0] RamFourBanks = 2'd2;

    // control write constants
    localparam logic [3:0] EnableKey    = 4'hA;
    localparam logic [3:0] RamMapLast   = 4'h3;
    localparam logic [3:0] RtcMapFirst  = 4'h8;
    localparam logic [3:0] RtcMapLast   = 4'hC;
    localparam logic [3:0] RtcMapFloor  = 4'h4;
    localparam logic [7:0] NoRamByte    = 8'hFF;
    localparam logic [RomBankBits-1:0] RomBankReset = 7'd1;

    // one classified access in the queue
    typedef struct packed {
        kind_t                   kind;
        logic [RomAddrBits-1:0]  rom_address;
        logic [7:0]              read_data;
        logic                    ram_enabled;
        logic [RamIndexBits-1:0] ram_index;
        logic [7:0]              write_data;
    } entry_t;

endpackage

/* hw/rtl/cbc_ram.sv */
// generic single write port ram with registered read
module cbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/cbc_queue.sv */
// short queue of classified accesses between front and back
module cbc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  cbc_pkg::entry_t push_entry,
    output logic            full,
    output logic            pop_valid,
    output cbc_pkg::entry_t pop_entry,
    input  logic            pop
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    cbc_pkg::entry_t slots_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign full      = (count_reg == FullCnt);
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slots_reg[rd_ptr_reg];

endmodule

/* hw/rtl/cbc_front.sv */
// front part: configuration, bank registers and access classification
module cbc_front #(
    parameter int RAM_BANKS = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_write_en,
    input  logic [cbc_pkg::CfgIndexBits-1:0]     cfg_index,
    input  logic [cbc_pkg::CfgDataBits-1:0]      cfg_write_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [2:0]                           s_action,
    input  logic [14:0]                          s_address,
    input  logic [7:0]                           s_write_data,
    input  logic                                 queue_full,
    output logic                                 push,
    output cbc_pkg::entry_t                      push_entry
);

    localparam logic [2:0] BanksW = 3'(RAM_BANKS);

    // configuration registers
    logic [2:0] rom_size_code_reg;
    logic [1:0] ram_size_reg;
    logic       rtc_present_reg;

    // mapping state
    logic                            ram_enable_flag_reg, ram_enable_flag_next;
    logic [3:0]                      map_select_reg, map_select_next;
    logic [cbc_pkg::RomBankBits-1:0] rom_bank_reg, rom_bank_next;
    logic [1:0]                      ram_bank_reg, ram_bank_next;

    logic                            accept;
    logic                            has_ram;
    logic                            ram_mapped;
    logic [cbc_pkg::RomBankBits-1:0] rom_mask;
    logic [cbc_pkg::RomBankBits-1:0] bank_masked;
    logic [3:0]                      nibble;
    logic [3:0]                      ram_sel;
    logic [2:0]                      bank_wrap;

    assign s_ready    = !queue_full;
    assign accept     = s_valid && s_ready;
    assign push       = accept;
    assign has_ram    = (ram_size_reg == cbc_pkg::RamOneBank)
                     || (ram_size_reg == cbc_pkg::RamFourBanks);
    assign ram_mapped = (map_select_reg < cbc_pkg::RtcMapFloor);
    assign nibble     = s_write_data[3:0];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_size_code_reg <= '0;
            ram_size_reg      <= '0;
            rtc_present_reg   <= 1'b0;
        end else if (cfg_write_en) begin
            unique case (cbc_pkg::cfg_index_t'(cfg_index))
                cbc_pkg::CFG_ROM_SIZE: rom_size_code_reg <= cfg_write_data[2:0];
                cbc_pkg::CFG_RAM_SIZE: ram_size_reg      <= cfg_write_data[1:0];
                cbc_pkg::CFG_RTC:      rtc_present_reg   <= cfg_write_data[0];
                default: ;
            endcase
        end
    end

    // rom bank mask from the size code, saturating at seven bits
    always_comb begin
        for (int i = 0; i < cbc_pkg::RomBankBits; i++) begin
            rom_mask[i] = (3'(i) <= rom_size_code_reg);
        end
        bank_masked = s_write_data[cbc_pkg::RomBankBits-1:0] & rom_mask;
    end

    // ram bank select wrapped to the number of banks fitted
    always_comb begin
        bank_wrap = (ram_size_reg == cbc_pkg::RamOneBank) ? 3'd0 : {1'b0, ram_bank_reg};
        for (int i = 0; i < 3; i++) begin
            if (bank_wrap >= BanksW) begin
                bank_wrap = bank_wrap - BanksW;
            end
        end
    end

    // control writes update the mapping state
    always_comb begin
        ram_enable_flag_next = ram_enable_flag_reg;
        map_select_next      = map_select_reg;
        rom_bank_next        = rom_bank_reg;
        ram_bank_next        = ram_bank_reg;
        ram_sel              = (ram_size_reg == cbc_pkg::RamOneBank) ? 4'd0 : nibble;
        if (accept && (cbc_pkg::action_t'(s_action) == cbc_pkg::ACT_CONTROL)) begin
            unique case (cbc_pkg::region_t'(s_address[14:13]))
                cbc_pkg::REGION_ENABLE: begin
                    ram_enable_flag_next = (nibble == cbc_pkg::EnableKey);
                end
                cbc_pkg::REGION_ROM_BANK: begin
                    rom_bank_next = (bank_masked == '0) ? cbc_pkg::RomBankReset : bank_masked;
                end
                cbc_pkg::REGION_RAM_BANK: begin
                    if (nibble <= cbc_pkg::RamMapLast) begin
                        if (has_ram) begin
                            map_select_next = ram_sel;
                            ram_bank_next   = ram_sel[1:0];
                        end
                    end else if (nibble >= cbc_pkg::RtcMapFirst
                              && nibble <= cbc_pkg::RtcMapLast) begin
                        if (rtc_present_reg) begin
                            map_select_next = nibble;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_enable_flag_reg <= 1'b0;
            map_select_reg      <= '0;
            rom_bank_reg        <= cbc_pkg::RomBankReset;
            ram_bank_reg        <= '0;
        end else begin
            ram_enable_flag_reg <= ram_enable_flag_next;
            map_select_reg      <= map_select_next;
            rom_bank_reg        <= rom_bank_next;
            ram_bank_reg        <= ram_bank_next;
        end
    end

    // classify the access for the back part
    always_comb begin
        push_entry             = '0;
        push_entry.kind        = cbc_pkg::KIND_PLAIN;
        push_entry.ram_enabled = ram_enable_flag_next;
        push_entry.ram_index   = {bank_wrap[cbc_pkg::RamBankSelBits-1:0],
                                  s_address[cbc_pkg::RamOffsetBits-1:0]};
        push_entry.write_data  = s_write_data;
        unique case (cbc_pkg::action_t'(s_action))
            cbc_pkg::ACT_ROM_FIXED: begin
                push_entry.rom_address = {{cbc_pkg::RomBankBits{1'b0}},
                                          s_address[cbc_pkg::RomOffsetBits-1:0]};
            end
            cbc_pkg::ACT_ROM_BANKED: begin
                push_entry.rom_address = {rom_bank_reg,
                                          s_address[cbc_pkg::RomOffsetBits-1:0]};
            end
            cbc_pkg::ACT_RAM_READ: begin
                if (ram_mapped) begin
                    if (has_ram) begin
                        push_entry.kind = cbc_pkg::KIND_RAM_READ;
                    end else begin
                        push_entry.read_data = cbc_pkg::NoRamByte;
                    end
                end
            end
            cbc_pkg::ACT_RAM_WRITE: begin
                if (ram_mapped && has_ram) begin
                    push_entry.kind = cbc_pkg::KIND_RAM_WRITE;
                end
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/cbc_back.sv */
// back part: ram access stage and result register
module cbc_back #(
    parameter int RAM_BANKS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                pop_valid,
    input  cbc_pkg::entry_t                     pop_entry,
    output logic                                pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cbc_pkg::RomAddrBits-1:0]     m_rom_address,
    output logic [7:0]                          m_read_data,
    output logic                                m_ram_enabled
);

    localparam int RamDepth = RAM_BANKS * (1 << cbc_pkg::RamOffsetBits);
    localparam int RamAw    = $clog2(RamDepth);

    // ram stage
    logic            s1_valid_reg;
    cbc_pkg::entry_t s1_entry_reg;

    // result register
    logic                            out_valid_reg;
    logic [cbc_pkg::RomAddrBits-1:0] out_rom_address_reg;
    logic [7:0]                      out_read_data_reg;
    logic                            out_ram_enabled_reg;

    logic             out_free;
    logic             s1_advance;
    logic             s1_free;
    logic             ram_we;
    logic             ram_re;
    logic [RamAw-1:0] ram_addr;
    logic [7:0]       ram_rdata;

    // stage handshakes
    assign out_free   = !out_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s1_free    = !s1_valid_reg || s1_advance;
    assign pop        = pop_valid && s1_free;
    assign ram_we     = pop && (pop_entry.kind == cbc_pkg::KIND_RAM_WRITE);
    assign ram_re     = pop && (pop_entry.kind == cbc_pkg::KIND_RAM_READ);
    assign ram_addr   = pop_entry.ram_index[RamAw-1:0];

    cbc_ram #(
        .WIDTH(8),
        .DEPTH(RamDepth)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata(pop_entry.write_data),
        .re   (ram_re),
        .raddr(ram_addr),
        .rdata(ram_rdata)
    );

    // ram stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_entry_reg <= pop_entry;
        end
    end

    // result register, ram data merged in here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            out_rom_address_reg <= s1_entry_reg.rom_address;
            out_read_data_reg   <= (s1_entry_reg.kind == cbc_pkg::KIND_RAM_READ)
                                 ? ram_rdata : s1_entry_reg.read_data;
            out_ram_enabled_reg <= s1_entry_reg.ram_enabled;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_rom_address = out_rom_address_reg;
    assign m_read_data   = out_read_data_reg;
    assign m_ram_enabled = out_ram_enabled_reg;

`ifndef SYNTHESIS
    // one ram port operation per cycle
    a_ram_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("ram read and write issued together");

    // a ram read lands in the ram stage on the next cycle
    a_read_in_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |=> (s1_valid_reg && (s1_entry_reg.kind == cbc_pkg::KIND_RAM_READ)))
        else $error("ram read not tracked by the ram stage");

    // a stalled ram stage takes nothing new and stays occupied
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && !$past(pop)))
        else $error("ram stage overwritten while stalled");
`endif

endmodule

/* hw/rtl/cartridge_bank_controller.sv */
// top level of the cartridge bank controller: front, queue and back
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_action, s_address, s_write_data
//  m_        out        m_valid / m_ready    m_rom_address, m_read_data, m_ram_enabled
//  cfg_      in         cfg_write_en         cfg_index, cfg_write_data
//
// one access per cycle sustained while m_ready stays high; a transfer passes through the
// queue slot written at the transfer edge, then the ram read stage and result register.
// reset clears mapping state, configuration and queue; ram contents are kept.
// the front stalls only when the queue is full; the back stalls only on m_ready.
module cartridge_bank_controller #(
    parameter int RAM_BANKS   = 4,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write_en,
    input  logic [cbc_pkg::CfgIndexBits-1:0]    cfg_index,
    input  logic [cbc_pkg::CfgDataBits-1:0]     cfg_write_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_action,
    input  logic [14:0]                         s_address,
    input  logic [7:0]                          s_write_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cbc_pkg::RomAddrBits-1:0]     m_rom_address,
    output logic [7:0]                          m_read_data,
    output logic                                m_ram_enabled
);

    logic            queue_full;
    logic            push;
    cbc_pkg::entry_t push_entry;
    logic            pop_valid;
    cbc_pkg::entry_t pop_entry;
    logic            pop;

    // decode and bank state
    cbc_front #(
        .RAM_BANKS(RAM_BANKS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_write_data(cfg_write_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_address     (s_address),
        .s_write_data  (s_write_data),
        .queue_full    (queue_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    // decoupling queue
    cbc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop       (pop)
    );

    // ram access and results
    cbc_back #(
        .RAM_BANKS(RAM_BANKS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_entry    (pop_entry),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rom_address(m_rom_address),
        .m_read_data  (m_read_data),
        .m_ram_enabled(m_ram_enabled)
    );

endmodule
